// File: rtl/slcd_pkg.sv
`default_nettype none

package slcd_pkg;

  localparam int unsigned BUF_DEPTH    = 64;
  localparam int unsigned ADDR_W       = $clog2(BUF_DEPTH);
  localparam int unsigned CNT_W        = $clog2(BUF_DEPTH + 1);
  localparam int unsigned HEAD_LEN     = 7;
  localparam int unsigned LEN_HIGH_POS = 4;
  localparam int unsigned LEN_LOW_POS  = 5;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'h55;
  localparam logic [7:0] SYNC_SECOND_RST = 8'hAA;

  // register index, taken from the word address
  localparam logic REG_SYNC_FIRST  = 1'b0;
  localparam logic REG_SYNC_SECOND = 1'b1;

  typedef enum logic [2:0] {
    OFF_HOLD,
    OFF_CLR,
    OFF_INC1,
    OFF_INC2,
    OFF_ADD_LEN
  } off_op_e;

  typedef enum logic [2:0] {
    REL_ZERO,
    REL_ONE,
    REL_LENH,
    REL_LENL,
    REL_IDX,
    REL_IDX1
  } rd_sel_e;

  typedef struct packed {
    logic    wr_en;
    off_op_e off_op;
    rd_sel_e rd_sel;
    logic    lenh_ld;
    logic    len_ld;
    logic    sum_step;
    logic    idx_clr;
    logic    emit_ld;
    logic    commit;
  } cmd_t;

  typedef struct packed {
    logic room_ok;
    logic sync1_ok;
    logic sync2_ok;
    logic len_bad;
    logic len_wait;
    logic sum_last;
    logic csum_ok;
    logic emit_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/sync_length_checksum_deframer.sv
// Frame parser for a byte stream from a serial link.
// Input channel: one rx_byte_i per transfer (in_valid_i / in_stall_o). Each
// byte is appended to a 64-byte circular buffer, then the buffer is rescanned
// from its oldest byte for frames: two sync bytes, a 16-bit length at bytes
// 4 and 5 counting the whole frame, and a trailing 8-bit additive checksum.
// Output channel: each byte of an accepted frame is one transfer
// (out_valid_o / out_stall_i) with frame_start_o and frame_last_o marks.
// The buffer memory has a single read port, so the rescan reads one byte at
// a time; no new input byte is taken until the rescan for the previous one ends.
// After a good checksum the emit state loads the first frame byte for transfer.
// A stalled receiver holds the output register and only the emission
// waits; scanning resumes once the last frame byte is loaded for transfer.
// Sync bytes are programmed over APB at byte addresses 0 and 4.
// Reset empties the buffer and restores sync values 0x55 and 0xAA.
`default_nettype none

module sync_length_checksum_deframer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       frame_byte_o,
  output logic             frame_start_o,
  output logic             frame_last_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  slcd_pkg::cmd_t cmd;
  slcd_pkg::sts_t sts;

  logic [7:0] sync_first_q;
  logic [7:0] sync_second_q;
  logic       cfg_wr;
  logic       reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= slcd_pkg::SYNC_FIRST_RST;
      sync_second_q <= slcd_pkg::SYNC_SECOND_RST;
    end else if (cfg_wr) begin
      if (reg_sel == slcd_pkg::REG_SYNC_FIRST) begin
        sync_first_q <= pwdata[7:0];
      end else begin
        sync_second_q <= pwdata[7:0];
      end
    end
  end

  assign prdata = (reg_sel == slcd_pkg::REG_SYNC_FIRST) ? {24'd0, sync_first_q}
                                                        : {24'd0, sync_second_q};

  slcd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  slcd_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .rx_byte_i     (rx_byte_i),
    .sync_first_i  (sync_first_q),
    .sync_second_i (sync_second_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .frame_byte_o  (frame_byte_o),
    .frame_start_o (frame_start_o),
    .frame_last_o  (frame_last_o)
  );

  // a pending output byte is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit_ld |-> sts.out_free)
    else $error("output register loaded while a transfer is pending");

  // no scan or emission work while the input side is open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> (!cmd.emit_ld && !cmd.sum_step && !cmd.len_ld))
    else $error("datapath busy while accepting input");

  // an accepted byte is always followed by a scan cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted without a following scan");

endmodule

`default_nettype wire

// File: rtl/slcd_datapath.sv
`default_nettype none

module slcd_datapath (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire slcd_pkg::cmd_t cmd_i,
  output slcd_pkg::sts_t     sts_o,
  input  wire logic [7:0]    rx_byte_i,
  input  wire logic [7:0]    sync_first_i,
  input  wire logic [7:0]    sync_second_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [7:0]         frame_byte_o,
  output logic               frame_start_o,
  output logic               frame_last_o
);

  localparam int unsigned AW = slcd_pkg::ADDR_W;
  localparam int unsigned CW = slcd_pkg::CNT_W;

  logic [7:0] mem [slcd_pkg::BUF_DEPTH];

  // circular buffer: head_q marks the oldest unconsumed byte
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [CW-1:0] off_q, off_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] len_q, len_d;
  logic [7:0]    sum_q, sum_d;
  logic [7:0]    lenh_q, lenh_d;
  logic [7:0]    rdata_q;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    obyte_q, obyte_d;
  logic          ofirst_q, ofirst_d;
  logic          olast_q, olast_d;

  logic          full;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] rel;
  logic [CW-1:0] avail;
  logic [CW-1:0] idx_inc;

  assign full    = (fill_q == CW'(slcd_pkg::BUF_DEPTH));
  assign wr_addr = head_q + fill_q[AW-1:0];
  assign avail   = fill_q - off_q;
  assign idx_inc = idx_q + CW'(1);

  always_comb begin
    case (cmd_i.rd_sel)
      slcd_pkg::REL_ZERO: rel = '0;
      slcd_pkg::REL_ONE:  rel = CW'(1);
      slcd_pkg::REL_LENH: rel = CW'(slcd_pkg::LEN_HIGH_POS);
      slcd_pkg::REL_LENL: rel = CW'(slcd_pkg::LEN_LOW_POS);
      slcd_pkg::REL_IDX:  rel = idx_q;
      slcd_pkg::REL_IDX1: rel = idx_inc;
      default:            rel = '0;
    endcase
  end

  assign rd_addr = head_q + off_q[AW-1:0] + rel[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && !full) begin
      mem[wr_addr] <= rx_byte_i;
    end
    rdata_q <= mem[rd_addr];
  end

  always_comb begin
    head_d      = head_q;
    fill_d      = fill_q;
    off_d       = off_q;
    idx_d       = idx_q;
    len_d       = len_q;
    sum_d       = sum_q;
    lenh_d      = lenh_q;
    out_valid_d = out_valid_q && out_stall_i;
    obyte_d     = obyte_q;
    ofirst_d    = ofirst_q;
    olast_d     = olast_q;

    if (cmd_i.wr_en && !full) begin
      fill_d = fill_q + CW'(1);
    end
    if (cmd_i.commit) begin
      head_d = head_q + off_q[AW-1:0];
      fill_d = fill_q - off_q;
    end

    case (cmd_i.off_op)
      slcd_pkg::OFF_HOLD:    off_d = off_q;
      slcd_pkg::OFF_CLR:     off_d = '0;
      slcd_pkg::OFF_INC1:    off_d = off_q + CW'(1);
      slcd_pkg::OFF_INC2:    off_d = off_q + CW'(2);
      slcd_pkg::OFF_ADD_LEN: off_d = off_q + len_q;
      default:               off_d = off_q;
    endcase

    if (cmd_i.lenh_ld) begin
      lenh_d = rdata_q;
    end
    if (cmd_i.len_ld) begin
      len_d = rdata_q[CW-1:0];
      sum_d = '0;
      idx_d = '0;
    end
    if (cmd_i.sum_step) begin
      sum_d = sum_q + rdata_q;
      idx_d = idx_inc;
    end
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end
    if (cmd_i.emit_ld) begin
      out_valid_d = 1'b1;
      obyte_d     = rdata_q;
      ofirst_d    = (idx_q == '0);
      olast_d     = (idx_inc == len_q);
      idx_d       = idx_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      fill_q      <= '0;
      off_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      fill_q      <= fill_d;
      off_q       <= off_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    len_q    <= len_d;
    sum_q    <= sum_d;
    lenh_q   <= lenh_d;
    obyte_q  <= obyte_d;
    ofirst_q <= ofirst_d;
    olast_q  <= olast_d;
  end

  assign sts_o.room_ok   = (avail >= CW'(slcd_pkg::HEAD_LEN));
  assign sts_o.sync1_ok  = (rdata_q == sync_first_i);
  assign sts_o.sync2_ok  = (rdata_q == sync_second_i);
  // rdata_q holds the low length byte when this is looked at
  assign sts_o.len_bad   = (lenh_q != 8'd0)
                        || (rdata_q > 8'(slcd_pkg::BUF_DEPTH))
                        || (rdata_q < 8'(slcd_pkg::HEAD_LEN));
  assign sts_o.len_wait  = ({1'b0, avail} < {1'b0, rdata_q[CW-1:0]});
  assign sts_o.sum_last  = ((idx_q + CW'(2)) == len_q);
  assign sts_o.csum_ok   = (rdata_q == sum_q);
  assign sts_o.emit_last = (idx_inc == len_q);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign frame_byte_o  = obyte_q;
  assign frame_start_o = ofirst_q;
  assign frame_last_o  = olast_q;

endmodule

`default_nettype wire

// File: rtl/slcd_ctrl.sv
`default_nettype none

module slcd_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  output slcd_pkg::cmd_t      cmd_o,
  input  wire slcd_pkg::sts_t sts_i
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CHECK = 9'b000000010,
    S_SYNC1 = 9'b000000100,
    S_SYNC2 = 9'b000001000,
    S_LENH  = 9'b000010000,
    S_LENL  = 9'b000100000,
    S_SUM   = 9'b001000000,
    S_CSUM  = 9'b010000000,
    S_EMIT  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // each state issues the read whose data the next state looks at
  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.off_op   = slcd_pkg::OFF_HOLD;
    cmd_o.rd_sel   = slcd_pkg::REL_IDX;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.off_op = slcd_pkg::OFF_CLR;
          state_d      = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.room_ok) begin
          cmd_o.rd_sel = slcd_pkg::REL_ZERO;
          state_d      = S_SYNC1;
        end else begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_SYNC1: begin
        cmd_o.rd_sel = slcd_pkg::REL_ONE;
        if (!sts_i.sync1_ok) begin
          cmd_o.off_op = slcd_pkg::OFF_INC1;
          state_d      = S_CHECK;
        end else begin
          state_d = S_SYNC2;
        end
      end
      S_SYNC2: begin
        cmd_o.rd_sel = slcd_pkg::REL_LENH;
        if (!sts_i.sync2_ok) begin
          cmd_o.off_op = slcd_pkg::OFF_INC1;
          state_d      = S_CHECK;
        end else begin
          state_d = S_LENH;
        end
      end
      S_LENH: begin
        cmd_o.rd_sel  = slcd_pkg::REL_LENL;
        cmd_o.lenh_ld = 1'b1;
        state_d       = S_LENL;
      end
      S_LENL: begin
        cmd_o.rd_sel = slcd_pkg::REL_ZERO;
        if (sts_i.len_bad) begin
          cmd_o.off_op = slcd_pkg::OFF_INC2;
          state_d      = S_CHECK;
        end else if (sts_i.len_wait) begin
          // frame not complete yet: keep it for the next byte
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end else begin
          cmd_o.len_ld = 1'b1;
          state_d      = S_SUM;
        end
      end
      S_SUM: begin
        cmd_o.rd_sel   = slcd_pkg::REL_IDX1;
        cmd_o.sum_step = 1'b1;
        if (sts_i.sum_last) begin
          state_d = S_CSUM;
        end
      end
      S_CSUM: begin
        cmd_o.rd_sel = slcd_pkg::REL_ZERO;
        if (!sts_i.csum_ok) begin
          cmd_o.off_op = slcd_pkg::OFF_INC2;
          state_d      = S_CHECK;
        end else begin
          cmd_o.idx_clr = 1'b1;
          state_d       = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_ld = 1'b1;
          cmd_o.rd_sel  = slcd_pkg::REL_IDX1;
          if (sts_i.emit_last) begin
            cmd_o.off_op = slcd_pkg::OFF_ADD_LEN;
            state_d      = S_CHECK;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

`default_nettype wire
